// File: hw/rtl/hmts_pkg.sv
// Shared constants for the height map triangle sampler.
// Used by the channel interfaces and the top level.
package hmts_pkg;

	localparam int MAX_SIDE    = 256;
	localparam int FRAC_BITS   = 8;
	localparam int SAMPLE_W    = 8;
	localparam int COORD_W     = 16;
	localparam int HEIGHT_W    = 16;
	localparam int SCALE_W     = 16;
	localparam int SIDE_W      = $clog2(MAX_SIDE) + 1;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_IDX_W   = 1;

	localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int BANK_DEPTH  = STORE_DEPTH / 2;
	localparam int BANK_AW     = ADDR_W - 1;

	localparam int CELL_W      = COORD_W - FRAC_BITS;
	localparam int WGT_W       = FRAC_BITS + 1;
	localparam int ACC_W       = SAMPLE_W + FRAC_BITS;
	localparam int PROD_W      = ACC_W + SCALE_W;
	localparam int SHIFT       = FRAC_BITS + 8;

	localparam logic [WGT_W-1:0]   ONE        = WGT_W'(1) << FRAC_BITS;
	localparam logic [SIDE_W-1:0]  SIDE_RST   = SIDE_W'(MAX_SIDE);
	localparam logic [SCALE_W-1:0] SCALE_RST  = SCALE_W'(13107);
	localparam logic [SIDE_W-1:0]  SIDE_MIN   = SIDE_W'(2);

	typedef enum logic {
		FUNC_LOAD  = 1'b0,
		FUNC_QUERY = 1'b1
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAP_SIDE     = 1'b0,
		REG_HEIGHT_SCALE = 1'b1
	} reg_idx_t;

endpackage

// File: hw/rtl/hmts_ifs.sv
// Valid/ready channel interfaces of the height map triangle sampler.
// Depends on hmts_pkg for field widths.
interface hmts_req_if;
	logic                                      valid;
	logic                                      ready;
	logic                                      func;
	logic [hmts_pkg::ADDR_W-1:0]               sample_index;
	logic [hmts_pkg::SAMPLE_W-1:0]             sample_value;
	logic [hmts_pkg::COORD_W-1:0]              query_col;
	logic [hmts_pkg::COORD_W-1:0]              query_row;

	modport source (output valid, func, sample_index, sample_value, query_col, query_row,
		input ready);
	modport sink (input valid, func, sample_index, sample_value, query_col, query_row,
		output ready);
endinterface

interface hmts_rsp_if;
	logic                                      valid;
	logic                                      ready;
	logic [hmts_pkg::HEIGHT_W-1:0]             height;
	logic                                      in_range;

	modport source (output valid, height, in_range, input ready);
	modport sink (input valid, height, in_range, output ready);
endinterface

interface hmts_cfg_if;
	logic                                      valid;
	logic                                      ready;
	logic [hmts_pkg::CFG_IDX_W-1:0]            index;
	logic [hmts_pkg::CFG_DATA_W-1:0]           data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/hmts_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; no package dependency.
module hmts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold the last word when no read is issued
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/heightmap_triangle_height_sample.sv
// Height map sampler: loads give no result; a query's bank read is registered at the edge
// that accepts it, then come the triangle blend, scale multiply and output registers. A new
// query or load is taken every cycle unless rsp.ready holds the pipeline back. The rate
// comes from the four 8-bit bank RAMs:
// the grid is held twice (upper-row copy and lower-row copy), each split by address parity,
// so the four cell corners are read in the same cycle, one read port per bank. The store has
// no clear after reset; querying a cell that was never loaded returns an undefined height.
// Depends on hmts_pkg, hmts_ifs and hmts_ram.
module heightmap_triangle_height_sample (
	input  logic        clk,
	input  logic        arst_n,
	hmts_req_if.sink    req,
	hmts_rsp_if.source  rsp,
	hmts_cfg_if.sink    cfg
);

	localparam int AW  = hmts_pkg::ADDR_W;
	localparam int BAW = hmts_pkg::BANK_AW;
	localparam int SW  = hmts_pkg::SIDE_W;
	localparam int CW  = hmts_pkg::CELL_W;
	localparam int FB  = hmts_pkg::FRAC_BITS;
	localparam int WW  = hmts_pkg::WGT_W;
	localparam int HW  = hmts_pkg::SAMPLE_W;

	// configuration
	logic [SW-1:0]                   map_side_q;
	logic [hmts_pkg::SCALE_W-1:0]    height_scale_q;
	logic [SW-1:0]                   side;
	logic [SW-1:0]                   tile;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_side_q     <= hmts_pkg::SIDE_RST;
			height_scale_q <= hmts_pkg::SCALE_RST;
		end else if (cfg.valid) begin
			case (hmts_pkg::reg_idx_t'(cfg.index))
				hmts_pkg::REG_MAP_SIDE:     map_side_q     <= cfg.data[SW-1:0];
				hmts_pkg::REG_HEIGHT_SCALE: height_scale_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (map_side_q < hmts_pkg::SIDE_MIN) begin
			side = hmts_pkg::SIDE_MIN;
		end else if (map_side_q > SW'(hmts_pkg::MAX_SIDE)) begin
			side = SW'(hmts_pkg::MAX_SIDE);
		end else begin
			side = map_side_q;
		end
	end
	assign tile = side - SW'(1);

	// pipeline handshake
	logic valid_s1, valid_s2, valid_s3, out_valid_q;
	logic s1_free, s2_free, s3_free, out_free;
	logic accept, is_query, is_load;

	assign out_free = !out_valid_q || rsp.ready;
	assign s3_free  = !valid_s3 || out_free;
	assign s2_free  = !valid_s2 || s3_free;
	assign s1_free  = !valid_s1 || s2_free;
	assign req.ready = s1_free;

	assign accept   = req.valid && s1_free;
	assign is_query = accept && (hmts_pkg::func_t'(req.func) == hmts_pkg::FUNC_QUERY);
	assign is_load  = accept && (hmts_pkg::func_t'(req.func) == hmts_pkg::FUNC_LOAD);

	// load path
	logic [2*SW-1:0] grid_size;
	logic            load_ok;

	assign grid_size = (2*SW)'(side) * (2*SW)'(side);
	assign load_ok   = is_load && ((2*SW)'(req.sample_index) < grid_size);

	// query decode
	logic [CW-1:0] cx, cz;
	logic [FB-1:0] fx, fz;
	logic          q_in_range;
	logic [AW:0]   base_full;
	logic [AW-1:0] base_top, base_bot, base_top1, base_bot1;
	logic [WW-1:0] fsum, w_a, w_1, w_2;
	logic          lower_tri;

	assign cx = req.query_col[hmts_pkg::COORD_W-1:FB];
	assign cz = req.query_row[hmts_pkg::COORD_W-1:FB];
	assign fx = req.query_col[FB-1:0];
	assign fz = req.query_row[FB-1:0];

	assign q_in_range = (cx != '0) && (cz != '0)
		&& (SW'(cx) < tile) && (SW'(cz) < tile);

	assign base_full = (AW+1)'(cz) * (AW+1)'(side) + (AW+1)'(cx);
	assign base_top  = base_full[AW-1:0];
	assign base_bot  = base_top + AW'(side);
	assign base_top1 = base_top + AW'(1);
	assign base_bot1 = base_bot + AW'(1);

	assign fsum      = WW'(fx) + WW'(fz);
	assign lower_tri = !(fsum < hmts_pkg::ONE);
	assign w_a = lower_tri ? (fsum - hmts_pkg::ONE) : (hmts_pkg::ONE - fsum);
	assign w_1 = lower_tri ? (hmts_pkg::ONE - WW'(fx)) : WW'(fx);
	assign w_2 = lower_tri ? (hmts_pkg::ONE - WW'(fz)) : WW'(fz);

	// bank RAMs: top row pair and bottom row pair, each split even/odd
	logic [HW-1:0] top_even, top_odd, bot_even, bot_odd;
	logic          we_even, we_odd;

	assign we_even = load_ok && !req.sample_index[0];
	assign we_odd  = load_ok && req.sample_index[0];

	hmts_ram #(.WIDTH(HW), .DEPTH(hmts_pkg::BANK_DEPTH)) u_top_even (
		.clk, .we(we_even), .waddr(req.sample_index[AW-1:1]), .wdata(req.sample_value),
		.re(is_query), .raddr(base_top1[AW-1:1]), .rdata(top_even)
	);
	hmts_ram #(.WIDTH(HW), .DEPTH(hmts_pkg::BANK_DEPTH)) u_top_odd (
		.clk, .we(we_odd), .waddr(req.sample_index[AW-1:1]), .wdata(req.sample_value),
		.re(is_query), .raddr(base_top[AW-1:1]), .rdata(top_odd)
	);
	hmts_ram #(.WIDTH(HW), .DEPTH(hmts_pkg::BANK_DEPTH)) u_bot_even (
		.clk, .we(we_even), .waddr(req.sample_index[AW-1:1]), .wdata(req.sample_value),
		.re(is_query), .raddr(base_bot1[AW-1:1]), .rdata(bot_even)
	);
	hmts_ram #(.WIDTH(HW), .DEPTH(hmts_pkg::BANK_DEPTH)) u_bot_odd (
		.clk, .we(we_odd), .waddr(req.sample_index[AW-1:1]), .wdata(req.sample_value),
		.re(is_query), .raddr(base_bot[AW-1:1]), .rdata(bot_odd)
	);

	// stage 1: bank data arrives, weights held alongside
	logic          in_range_s1, lower_s1, top_odd_s1, bot_odd_s1;
	logic [WW-1:0] w_a_s1, w_1_s1, w_2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= is_query;
		end
	end

	always_ff @(posedge clk) begin
		if (is_query) begin
			in_range_s1 <= q_in_range;
			lower_s1    <= lower_tri;
			top_odd_s1  <= base_top[0];
			bot_odd_s1  <= base_bot[0];
			w_a_s1      <= w_a;
			w_1_s1      <= w_1;
			w_2_s1      <= w_2;
		end
	end

	// stage 2: triangle blend
	logic [HW-1:0]              h0, h1, h2, h3, h_a;
	logic [HW+WW+1:0]           blend;
	logic [hmts_pkg::ACC_W-1:0] acc_s2;
	logic                       in_range_s2;

	assign h0  = top_odd_s1 ? top_odd : top_even;
	assign h1  = top_odd_s1 ? top_even : top_odd;
	assign h2  = bot_odd_s1 ? bot_odd : bot_even;
	assign h3  = bot_odd_s1 ? bot_even : bot_odd;
	assign h_a = lower_s1 ? h3 : h0;

	assign blend = (HW+WW+2)'(h_a) * (HW+WW+2)'(w_a_s1)
		+ (HW+WW+2)'(h1) * (HW+WW+2)'(w_1_s1)
		+ (HW+WW+2)'(h2) * (HW+WW+2)'(w_2_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			// drop the blend for rejected cells so the height comes out zero
			acc_s2      <= in_range_s1 ? blend[hmts_pkg::ACC_W-1:0] : '0;
			in_range_s2 <= in_range_s1;
		end
	end

	// stage 3: scale multiply
	logic [hmts_pkg::PROD_W-1:0] prod_s3;
	logic                        in_range_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s3_free) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_free && valid_s2) begin
			prod_s3     <= hmts_pkg::PROD_W'(acc_s2) * hmts_pkg::PROD_W'(height_scale_q);
			in_range_s3 <= in_range_s2;
		end
	end

	// output register: round half up, shift down, saturate
	localparam int SH = hmts_pkg::SHIFT;
	localparam int RW = hmts_pkg::PROD_W + 1;

	logic [RW-1:0]                 rounded;
	logic [RW-SH-1:0]              shifted;
	logic [hmts_pkg::HEIGHT_W-1:0] height_sat;
	logic [hmts_pkg::HEIGHT_W-1:0] height_q;
	logic                          in_range_q;

	assign rounded    = RW'(prod_s3) + (RW'(1) << (SH - 1));
	assign shifted    = rounded[RW-1:SH];
	assign height_sat = (shifted > (RW-SH)'({hmts_pkg::HEIGHT_W{1'b1}}))
		? {hmts_pkg::HEIGHT_W{1'b1}} : hmts_pkg::HEIGHT_W'(shifted);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s3) begin
			height_q   <= height_sat;
			in_range_q <= in_range_s3;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.height   = height_q;
	assign rsp.in_range = in_range_q;

`ifndef ASSERT_OFF
	a_load_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		is_load |=> !valid_s1)
		else $error("load word entered the query pipeline");

	a_query_enters: assert property (@(posedge clk) disable iff (!arst_n)
		is_query |=> valid_s1)
		else $error("accepted query lost before stage 1");

	a_weights_sum: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ((WW+2)'(w_a_s1) + (WW+2)'(w_1_s1) + (WW+2)'(w_2_s1)
			== (WW+2)'(hmts_pkg::ONE)))
		else $error("triangle weights do not sum to one");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.in_range) |-> (rsp.height == '0))
		else $error("rejected query returned a nonzero height");

	a_no_write_on_query: assert property (@(posedge clk) disable iff (!arst_n)
		is_query |-> !(we_even || we_odd))
		else $error("bank write during a query");
`endif

endmodule
